@@ src/ardb_pkg.sv @@
// ----------------------------------------------------------------------------
// ardb_pkg - shared types and constants for the RMS dBFS level meter
// Field widths, fixed-point constants and the sequencer state encoding.
// ----------------------------------------------------------------------------
package ardb_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_BLOCK   = 4096;
  localparam int SUM_W       = 43;   // sum of squares of a full block
  localparam int CNT_W       = 13;   // holds MAX_BLOCK itself
  localparam int LVL_W       = 16;   // Q1.15 level
  localparam int FRAC_W      = 16;   // log2 fraction bits
  localparam int EXP_W       = 6;    // log2 integer part, 0..42
  localparam int LOG_W       = EXP_W + FRAC_W;
  localparam int L_W         = LOG_W + 2;  // signed log difference
  localparam int MANT_W      = 32;
  localparam int MUL_W       = 32;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int N_W         = FRAC_W + 1; // n in Q.16, up to 1.0

  // full-scale reference for squares: 2^FSX
  localparam int FSX = 2 * (SAMPLE_BITS - 1);

  // round(log10(2)/6 * 2^32)
  localparam logic [27:0] DB_SLOPE = 28'd215485664;

  localparam logic [LVL_W-1:0] THR_RESET = 16'd164;

  localparam logic [0:0] OP_SAMPLE = 1'b0;
  localparam logic [0:0] OP_STOP   = 1'b1;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_SQR    = 11'b000_0000_0010,
    ST_ACC    = 11'b000_0000_0100,
    ST_NORM   = 11'b000_0000_1000,
    ST_LOGMUL = 11'b000_0001_0000,
    ST_LOGUPD = 11'b000_0010_0000,
    ST_DIFF   = 11'b000_0100_0000,
    ST_MULK   = 11'b000_1000_0000,
    ST_DROP   = 11'b001_0000_0000,
    ST_SQN    = 11'b010_0000_0000,
    ST_UPD    = 11'b100_0000_0000
  } state_t;

endpackage

@@ src/audio_rms_db_level_meter.sv @@
// ----------------------------------------------------------------------------
// audio_rms_db_level_meter - block RMS meter with a perceptual dBFS curve
// Accumulates squares of signed samples per block, then maps 10*log10 of the
// mean square, clamped to -60..0 dB, onto a squared 0..1 level in Q1.15.
// ----------------------------------------------------------------------------
// Usage: send samples (op = 0) with last set on the final sample of a block;
// a block also closes by itself at MAX_BLOCK samples. Each block end yields
// one result transaction (level, changed); a stop (op = 1) clears the
// accumulators and the level and yields one result as well. Other samples
// yield nothing. The input is stalled while an item is worked on and while a
// finished result still waits for the output register. A sample inside a
// block passes through accept, squaring on the shared multiplier and
// accumulation. A block end adds two log2 evaluations, each a normalizing
// shift of one bit a cycle and 16 squaring steps on the shared 32x32
// multiplier, then dB mapping, the update and a hand-over of the result to
// the output register. A block of all-zero samples skips the log2 work. A
// stalled result in the output register keeps the next finished result
// waiting and so stalls the input. A result waits in the output register
// while the next item is taken. The change threshold is written over the
// cfg channel, which is always ready; write it only while the block is
// idle.
module audio_rms_db_level_meter (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ardb_pkg::LVL_W-1:0]   cfg_data,
  // input item channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [0:0]                   op,
  input  logic signed [ardb_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                         last,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ardb_pkg::LVL_W-1:0]   level,
  output logic                         changed
);
  import ardb_pkg::*;

  state_t state;

  // configuration
  logic [LVL_W-1:0] change_threshold;

  // block accumulators
  logic [SUM_W-1:0] square_sum;
  logic [CNT_W-1:0] sample_count;
  logic [LVL_W-1:0] current_level;

  // captured sample
  logic [SAMPLE_BITS-1:0] smag;
  logic                   last_r;

  // log2 unit
  logic [SUM_W-1:0]  norm;
  logic [EXP_W-1:0]  expo;
  logic [MANT_W-1:0] mant;
  logic [FRAC_W-1:0] frac;
  logic [3:0]        bitcnt;
  logic              which;     // 0: square sum, 1: sample count
  logic [LOG_W-1:0]  log_sum;
  logic [LOG_W-1:0]  log_cnt;

  // dB mapping
  logic [L_W-2:0]    mag;
  logic [N_W-1:0]    nval;
  logic [LVL_W-1:0]  new_level;

  // result waiting for the output register
  logic [LVL_W-1:0]  res_level;
  logic              res_changed;
  logic              res_pending;

  // shared multiplier, product registered every cycle
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQR: begin
        mul_a = MUL_W'(smag);
        mul_b = MUL_W'(smag);
      end
      ST_LOGMUL: begin
        mul_a = mant;
        mul_b = mant;
      end
      ST_MULK: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(DB_SLOPE);
      end
      ST_SQN: begin
        mul_a = MUL_W'(nval);
        mul_b = MUL_W'(nval);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // combinational helpers for the sequencer
  logic [SUM_W-1:0]     sum_next;
  logic [CNT_W-1:0]     cnt_next;
  logic                 block_end;
  logic [MANT_W-1:0]    mq;
  logic [FRAC_W-1:0]    frac_next;
  logic signed [L_W-1:0] ldiff;
  logic [PROD_W-1:0]    drop_rnd;
  logic [31:0]          drop;
  logic [33:0]          lvl_rnd;
  logic                 out_free;

  // final update rule, fed by the rounded n*n the cycle after ST_SQN
  logic                 from_sqn;
  logic [LVL_W-1:0]     upd_level;
  logic [LVL_W-1:0]     upd_diff;

  assign sum_next  = square_sum + SUM_W'(prod[2*SAMPLE_BITS-1:0]);
  assign cnt_next  = sample_count + CNT_W'(1);
  assign block_end = last_r || (cnt_next == CNT_W'(MAX_BLOCK));
  assign mq        = prod[2*MANT_W-3:MANT_W-2];   // (m*m) >> 30
  assign frac_next = {frac[FRAC_W-2:0], mq[MANT_W-1]};
  assign ldiff     = $signed({2'b00, log_sum}) - $signed({2'b00, log_cnt})
                     - $signed(L_W'(FSX << FRAC_W));
  assign drop_rnd  = prod + (PROD_W'(1) << 31);
  assign drop      = drop_rnd[63:32];
  assign lvl_rnd   = prod[33:0] + (34'd1 << FRAC_W);
  assign out_free  = !out_valid || !out_stall;

  assign upd_level = from_sqn ? lvl_rnd[FRAC_W+LVL_W:FRAC_W+1] : new_level;
  assign upd_diff  = (upd_level > current_level) ? (upd_level - current_level)
                                                 : (current_level - upd_level);

  // no new transaction while busy or while a result still waits
  assign in_stall  = (state != ST_IDLE) || res_pending;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      change_threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      change_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      from_sqn <= 1'b0;
    end else begin
      from_sqn <= (state == ST_SQN);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      square_sum    <= '0;
      sample_count  <= '0;
      current_level <= '0;
      res_pending   <= 1'b0;
    end else begin
      // a finished result moves to the output register once it is free
      if (res_pending && out_free) begin
        res_pending <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          // a new item is only taken once the previous result has left
          if (in_valid && !res_pending) begin
            if (op == OP_STOP) begin
              square_sum    <= '0;
              sample_count  <= '0;
              current_level <= '0;
              res_level     <= '0;
              res_changed   <= (current_level != '0);
              res_pending   <= 1'b1;
            end else begin
              smag   <= sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample)
                                              : SAMPLE_BITS'(sample);
              last_r <= last;
              state  <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          square_sum   <= sum_next;
          sample_count <= cnt_next;
          if (!block_end) begin
            state <= ST_IDLE;
          end else if (sum_next == '0) begin
            new_level <= '0;
            state     <= ST_UPD;
          end else begin
            norm  <= sum_next;
            expo  <= EXP_W'(SUM_W - 1);
            which <= 1'b0;
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (norm[SUM_W-1]) begin
            mant   <= {1'b0, norm[SUM_W-1:SUM_W-MANT_W+1]};
            frac   <= '0;
            bitcnt <= '0;
            state  <= ST_LOGMUL;
          end else begin
            norm <= {norm[SUM_W-2:0], 1'b0};
            expo <= expo - EXP_W'(1);
          end
        end
        ST_LOGMUL: begin
          state <= ST_LOGUPD;
        end
        ST_LOGUPD: begin
          mant   <= mq[MANT_W-1] ? {1'b0, mq[MANT_W-1:1]} : mq;
          frac   <= frac_next;
          bitcnt <= bitcnt + 4'd1;
          if (bitcnt != 4'd15) begin
            state <= ST_LOGMUL;
          end else if (!which) begin
            log_sum <= {expo, frac_next};
            norm    <= SUM_W'(sample_count);
            expo    <= EXP_W'(SUM_W - 1);
            which   <= 1'b1;
            state   <= ST_NORM;
          end else begin
            log_cnt <= {expo, frac_next};
            state   <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          if (!ldiff[L_W-1]) begin
            nval  <= N_W'(1) << FRAC_W;     // at or above full scale
            state <= ST_SQN;
          end else begin
            mag   <= (L_W-1)'(-ldiff);
            state <= ST_MULK;
          end
        end
        ST_MULK: begin
          state <= ST_DROP;
        end
        ST_DROP: begin
          if (drop[31:FRAC_W] != '0) begin
            new_level <= '0;                // below -60 dB
            state     <= ST_UPD;
          end else begin
            nval  <= (N_W'(1) << FRAC_W) - N_W'(drop[FRAC_W-1:0]);
            state <= ST_SQN;
          end
        end
        ST_SQN: begin
          // product of n*n appears in the next cycle; pass through ST_UPD
          // via the rounding below
          state <= ST_UPD;
          new_level <= '0;
        end
        ST_UPD: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // level of a squared n is ready the cycle after ST_SQN
      if (state == ST_UPD) begin
        square_sum   <= '0;
        sample_count <= '0;
        res_pending  <= 1'b1;
        if (upd_diff > change_threshold) begin
          current_level <= upd_level;
          res_level     <= upd_level;
          res_changed   <= 1'b1;
        end else begin
          res_level   <= current_level;
          res_changed <= 1'b0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_pending && out_free) begin
      out_valid <= 1'b1;
      level     <= res_level;
      changed   <= res_changed;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ src/ardb_checker.sv @@
// ----------------------------------------------------------------------------
// ardb_checker - port-level assertions for the level meter
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module ardb_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [ardb_pkg::LVL_W-1:0]   cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [0:0]                   op,
  input  logic signed [ardb_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                         last,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [ardb_pkg::LVL_W-1:0]   level,
  input  logic                         changed
);
  import ardb_pkg::*;

  logic unused_ok;
  assign unused_ok = cfg_valid ^ cfg_ready ^ (^cfg_data) ^ op[0] ^ (^sample) ^ last;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(level) && $stable(changed))
    else $error("stalled result changed");

  // level never exceeds 1.0 in Q1.15
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level <= 16'd32768)
    else $error("level above full scale");

  // every accepted item keeps the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted back to back");

  // reset leaves no result behind
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind audio_rms_db_level_meter ardb_checker u_ardb_checker (.*);
